FILE: src/rst_pkg.sv
// shared types, constants and functions of the ring sector tessellator
`default_nettype none

package rst_pkg;

    localparam int IDX_W        = 8;
    localparam int SEG_W        = 9;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int MIN_SEGMENTS = 3;
    localparam int MAX_SEGMENTS = 256;
    localparam int SINCOS_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;

    localparam int LANES        = 2;
    localparam int NQ           = 3;
    localparam int Q_ANG        = 0;
    localparam int Q_SCALE      = 1;
    localparam int Q_U          = 2;

    localparam int QUO_W        = 34;
    localparam int DIV_PER_ST   = 2;
    localparam int DIV_STAGES   = (QUO_W + DIV_PER_ST - 1) / DIV_PER_ST;
    localparam int NUM_W        = QUO_W + SEG_W;
    localparam int ANG_SHIFT    = 18;

    localparam int COR_PER_ST   = 2;
    localparam int COR_STAGES   = (SINCOS_STEPS + COR_PER_ST - 1) / COR_PER_ST;

    localparam int ANG_W        = 36;
    localparam int CORD_W       = 34;
    localparam int RAD_W        = 17;
    localparam int SCALE_W      = 15;
    localparam int U_W          = 17;
    localparam int RS_W         = 32;
    localparam int Q88_W        = 16;
    localparam int PL_W         = RS_W + 16;
    localparam int PH_W         = RS_W + 1 + CORD_W - 16;
    localparam int VNUM_W       = 11;
    localparam int VCNT_W       = 3;
    localparam int VERT_PER_SEG = 6;
    localparam int HALF_UNIT    = 128;

    localparam logic [VCNT_W-1:0] LAST_VERT = 3'd5;
    localparam logic [VERT_PER_SEG-1:0] PICK_EDGE  = 6'b110100;
    localparam logic [VERT_PER_SEG-1:0] PICK_OUTER = 6'b011010;

    localparam logic signed [ANG_W-1:0]  PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0]  TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [CORD_W-1:0] GAIN_Q30    = 34'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENT_COUNT = 3'd0,
        CFG_INNER_RADIUS  = 3'd1,
        CFG_OUTER_RADIUS  = 3'd2,
        CFG_FIRST_ANGLE   = 3'd3,
        CFG_LAST_ANGLE    = 3'd4,
        CFG_FIRST_SCALE   = 3'd5,
        CFG_LAST_SCALE    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [SEG_W-1:0]   n;
        logic [RAD_W-1:0]   ri;
        logic [RAD_W-1:0]   ro;
        logic signed [15:0] a0;
        logic [15:0]        da;
        logic [SCALE_W-1:0] s0;
        logic [SCALE_W-1:0] s1;
    } cfg_t;

    typedef struct packed {
        logic signed [Q88_W-1:0] x_in;
        logic signed [Q88_W-1:0] y_in;
        logic signed [Q88_W-1:0] x_out;
        logic signed [Q88_W-1:0] y_out;
        logic [U_W-1:0]          u;
    } edge_res_t;

    function automatic logic signed [CORD_W-1:0] atan_q30(input int k);
        logic signed [CORD_W-1:0] r;
        case (k)
            0:  r = 34'sh3243F6A8;
            1:  r = 34'sh1DAC6705;
            2:  r = 34'sh0FADBAFC;
            3:  r = 34'sh07F56EA6;
            4:  r = 34'sh03FEAB76;
            5:  r = 34'sh01FFD55B;
            6:  r = 34'sh00FFFAAA;
            7:  r = 34'sh007FFF55;
            8:  r = 34'sh003FFFEA;
            9:  r = 34'sh001FFFFD;
            10: r = 34'sh000FFFFF;
            11: r = 34'sh0007FFFF;
            12: r = 34'sh0003FFFF;
            13: r = 34'sh0001FFFF;
            14: r = 34'sh0000FFFF;
            15: r = 34'sh00007FFF;
            16: r = 34'sh00003FFF;
            17: r = 34'sh00001FFF;
            18: r = 34'sh00000FFF;
            19: r = 34'sh000007FF;
            20: r = 34'sh000003FF;
            21: r = 34'sh000001FF;
            22: r = 34'sh000000FF;
            23: r = 34'sh0000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/rst_if.sv
// item channels of the ring sector tessellator
`default_nettype none

interface rst_seg_if;
    logic                      valid;
    logic                      ready;
    logic [rst_pkg::IDX_W-1:0] segment_index;

    modport source (output valid, output segment_index, input ready);
    modport sink (input valid, input segment_index, output ready);
endinterface

interface rst_vtx_if;
    logic                             valid;
    logic                             ready;
    logic signed [rst_pkg::Q88_W-1:0] vertex_x;
    logic signed [rst_pkg::Q88_W-1:0] vertex_y;
    logic [rst_pkg::U_W-1:0]          tex_u;
    logic                             tex_v;
    logic [rst_pkg::VNUM_W-1:0]       vertex_number;
    logic                             final_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output tex_u,
                    output tex_v, output vertex_number, output final_vertex,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input tex_u,
                  input tex_v, input vertex_number, input final_vertex,
                  output ready);
endinterface

`default_nettype wire

FILE: src/rst_pipe.sv
// edge pipeline: interpolation dividers, angle reduction, cordic and scaling
`default_nettype none

module rst_pipe (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_valid,
    input  wire logic [rst_pkg::IDX_W-1:0]           in_index,
    input  wire rst_pkg::cfg_t                       cfg,
    output logic                                     out_valid,
    output logic [rst_pkg::IDX_W-1:0]                out_index,
    output rst_pkg::edge_res_t [rst_pkg::LANES-1:0]  out_res
);
    import rst_pkg::*;

    localparam int ST_NUM  = 1;
    localparam int ST_ANG  = ST_NUM + DIV_STAGES + 1;
    localparam int ST_RED  = ST_ANG + 1;
    localparam int ST_FOLD = ST_RED + 1;
    localparam int ST_MUL  = ST_FOLD + COR_STAGES + 1;
    localparam int ST_OUT  = ST_MUL + 1;

    typedef struct packed {
        logic [SEG_W-1:0] rem;
        logic [QUO_W-1:0] low;
    } div_t;

    function automatic div_t div_pair(input div_t d, input logic [SEG_W-1:0] n);
        div_t         r;
        logic [SEG_W:0] t;
        r = d;
        for (int s = 0; s < DIV_PER_ST; s++) begin
            t = {r.rem, r.low[QUO_W-1]};
            if (t >= {1'b0, n}) begin
                r.rem = SEG_W'(t - {1'b0, n});
                r.low = {r.low[QUO_W-2:0], 1'b1};
            end
            else begin
                r.rem = t[SEG_W-1:0];
                r.low = {r.low[QUO_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic signed [Q88_W-1:0] to_q88(input logic signed [PH_W-1:0] ph,
                                                       input logic [PL_W-1:0] pl);
        logic signed [63:0] f;
        logic signed [21:0] q;
        logic signed [Q88_W-1:0] r;
        f = (64'(ph) <<< 16) + $signed({16'b0, pl}) + (64'sd1 <<< 41);
        q = 22'(f >>> 42);
        if (q > 22'sd32767)
            r = 16'sh7FFF;
        else if (q < -22'sd32768)
            r = 16'sh8000;
        else
            r = q[Q88_W-1:0];
        return r;
    endfunction

    logic             vld_reg [0:ST_OUT];
    logic [IDX_W-1:0] idx_reg [0:ST_OUT];

    div_t div_reg [0:DIV_STAGES][0:LANES-1][0:NQ-1];

    logic signed [ANG_W-1:0] ang_reg [0:LANES-1];
    logic signed [ANG_W-1:0] red_reg [0:LANES-1];
    logic [RS_W-1:0]  rsi_reg [ST_ANG:ST_MUL-1][0:LANES-1];
    logic [RS_W-1:0]  rso_reg [ST_ANG:ST_MUL-1][0:LANES-1];
    logic [U_W-1:0]   u_reg   [ST_ANG:ST_MUL][0:LANES-1];
    logic             flip_reg [0:COR_STAGES][0:LANES-1];
    logic signed [CORD_W-1:0] cx_reg [0:COR_STAGES][0:LANES-1];
    logic signed [CORD_W-1:0] cy_reg [0:COR_STAGES][0:LANES-1];
    logic signed [CORD_W-1:0] ca_reg [0:COR_STAGES][0:LANES-1];
    logic signed [PH_W-1:0]   ph_reg [0:LANES-1][0:3];
    logic [PL_W-1:0]          pl_reg [0:LANES-1][0:3];
    edge_res_t                res_reg [0:LANES-1];

    // valid and index travel beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            idx_reg[0] <= in_index;
    end

    for (genvar k = 1; k <= ST_OUT; k++) begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                idx_reg[k] <= idx_reg[k-1];
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [SEG_W-1:0]   j_w;
        logic [7:0]         half_w;
        logic [24:0]        dj_w;
        logic [23:0]        ps0_w;
        logic [23:0]        ps1_w;
        logic [NUM_W-1:0]   num_a_w;
        logic [NUM_W-1:0]   num_s_w;
        logic [NUM_W-1:0]   num_u_w;
        logic [SCALE_W-1:0] q_s_w;
        logic signed [ANG_W-1:0] ang_next;
        logic signed [ANG_W-1:0] red_next;
        logic signed [ANG_W-1:0] fold_next;
        logic                    flip_next;
        logic signed [CORD_W-1:0] tx_w;
        logic signed [CORD_W-1:0] ty_w;

        // numerators of the three rounded quotients
        assign j_w     = SEG_W'(idx_reg[0]) + SEG_W'(l);
        assign half_w  = cfg.n[SEG_W-1:1];
        assign dj_w    = cfg.da * j_w;
        assign ps0_w   = cfg.s0 * (cfg.n - j_w);
        assign ps1_w   = cfg.s1 * j_w;
        assign num_a_w = (NUM_W'(dj_w) << ANG_SHIFT) + NUM_W'(half_w);
        assign num_s_w = NUM_W'(ps0_w) + NUM_W'(ps1_w) + NUM_W'(half_w);
        assign num_u_w = (NUM_W'(j_w) << 16) + NUM_W'(half_w);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[0][l][Q_ANG]   <= div_t'(num_a_w);
                div_reg[0][l][Q_SCALE] <= div_t'(num_s_w);
                div_reg[0][l][Q_U]     <= div_t'(num_u_w);
            end
        end

        for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
            for (genvar q = 0; q < NQ; q++) begin : g_q
                always_ff @(posedge clk)
                begin
                    if (adv)
                        div_reg[k][l][q] <= div_pair(div_reg[k-1][l][q], cfg.n);
                end
            end
        end

        // angle, scaled radii and u
        assign q_s_w    = div_reg[DIV_STAGES][l][Q_SCALE].low[SCALE_W-1:0];
        assign ang_next = ($signed({{(ANG_W-16){cfg.a0[15]}}, cfg.a0}) <<< ANG_SHIFT)
                        + $signed({{(ANG_W-QUO_W){1'b0}}, div_reg[DIV_STAGES][l][Q_ANG].low});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ang_reg[l]         <= ang_next;
                rsi_reg[ST_ANG][l] <= RS_W'(cfg.ri) * RS_W'(q_s_w);
                rso_reg[ST_ANG][l] <= RS_W'(cfg.ro) * RS_W'(q_s_w);
                u_reg[ST_ANG][l]   <= div_reg[DIV_STAGES][l][Q_U].low[U_W-1:0];
            end
        end

        for (genvar k = ST_ANG + 1; k < ST_MUL; k++) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rsi_reg[k][l] <= rsi_reg[k-1][l];
                    rso_reg[k][l] <= rso_reg[k-1][l];
                end
            end
        end

        for (genvar k = ST_ANG + 1; k <= ST_MUL; k++) begin : g_carry_u
            always_ff @(posedge clk)
            begin
                if (adv)
                    u_reg[k][l] <= u_reg[k-1][l];
            end
        end

        // reduce into one turn, then fold into the right half plane
        always_comb
        begin
            if (ang_reg[l] > PI_Q30)
                red_next = ang_reg[l] - TWO_PI_Q30;
            else if (ang_reg[l] < -PI_Q30)
                red_next = ang_reg[l] + TWO_PI_Q30;
            else
                red_next = ang_reg[l];
        end

        always_comb
        begin
            if (red_reg[l] > HALF_PI_Q30)
            begin
                fold_next = red_reg[l] - PI_Q30;
                flip_next = 1'b1;
            end
            else if (red_reg[l] < -HALF_PI_Q30)
            begin
                fold_next = red_reg[l] + PI_Q30;
                flip_next = 1'b1;
            end
            else
            begin
                fold_next = red_reg[l];
                flip_next = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                red_reg[l]     <= red_next;
                ca_reg[0][l]   <= CORD_W'(fold_next);
                cx_reg[0][l]   <= GAIN_Q30;
                cy_reg[0][l]   <= '0;
                flip_reg[0][l] <= flip_next;
            end
        end

        for (genvar c = 0; c < COR_STAGES; c++) begin : g_cor
            logic signed [CORD_W-1:0] x_next;
            logic signed [CORD_W-1:0] y_next;
            logic signed [CORD_W-1:0] a_next;

            always_comb
            begin
                logic signed [CORD_W-1:0] nx;
                x_next = cx_reg[c][l];
                y_next = cy_reg[c][l];
                a_next = ca_reg[c][l];
                for (int s = 0; s < COR_PER_ST; s++) begin
                    if ((c * COR_PER_ST + s < SINCOS_STEPS) &&
                        (c * COR_PER_ST + s < ATAN_ENTRIES))
                    begin
                        if (!a_next[CORD_W-1])
                        begin
                            nx     = x_next - (y_next >>> (c * COR_PER_ST + s));
                            y_next = y_next + (x_next >>> (c * COR_PER_ST + s));
                            a_next = a_next - atan_q30(c * COR_PER_ST + s);
                        end
                        else
                        begin
                            nx     = x_next + (y_next >>> (c * COR_PER_ST + s));
                            y_next = y_next - (x_next >>> (c * COR_PER_ST + s));
                            a_next = a_next + atan_q30(c * COR_PER_ST + s);
                        end
                        x_next = nx;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cx_reg[c+1][l]   <= x_next;
                    cy_reg[c+1][l]   <= y_next;
                    ca_reg[c+1][l]   <= a_next;
                    flip_reg[c+1][l] <= flip_reg[c][l];
                end
            end
        end

        // x uses minus sine, y uses cosine
        assign tx_w = flip_reg[COR_STAGES][l] ? cy_reg[COR_STAGES][l] : -cy_reg[COR_STAGES][l];
        assign ty_w = flip_reg[COR_STAGES][l] ? -cx_reg[COR_STAGES][l] : cx_reg[COR_STAGES][l];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pl_reg[l][0] <= rsi_reg[ST_MUL-1][l] * tx_w[15:0];
                pl_reg[l][1] <= rsi_reg[ST_MUL-1][l] * ty_w[15:0];
                pl_reg[l][2] <= rso_reg[ST_MUL-1][l] * tx_w[15:0];
                pl_reg[l][3] <= rso_reg[ST_MUL-1][l] * ty_w[15:0];
                ph_reg[l][0] <= $signed({1'b0, rsi_reg[ST_MUL-1][l]}) * $signed(tx_w[CORD_W-1:16]);
                ph_reg[l][1] <= $signed({1'b0, rsi_reg[ST_MUL-1][l]}) * $signed(ty_w[CORD_W-1:16]);
                ph_reg[l][2] <= $signed({1'b0, rso_reg[ST_MUL-1][l]}) * $signed(tx_w[CORD_W-1:16]);
                ph_reg[l][3] <= $signed({1'b0, rso_reg[ST_MUL-1][l]}) * $signed(ty_w[CORD_W-1:16]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                res_reg[l].x_in  <= to_q88(ph_reg[l][0], pl_reg[l][0]);
                res_reg[l].y_in  <= to_q88(ph_reg[l][1], pl_reg[l][1]);
                res_reg[l].x_out <= to_q88(ph_reg[l][2], pl_reg[l][2]);
                res_reg[l].y_out <= to_q88(ph_reg[l][3], pl_reg[l][3]);
                res_reg[l].u     <= u_reg[ST_MUL][l];
            end
        end

        assign out_res[l] = res_reg[l];
    end

    assign out_valid = vld_reg[ST_OUT];
    assign out_index = idx_reg[ST_OUT];

endmodule

`default_nettype wire

FILE: src/ring_sector_tessellator_unit.sv
// top level of the ring sector tessellator
//
// seg_in takes one segment index per item; vtx_out gives the six vertices
// of that segment's two triangles, inner0 outer0 inner1 then outer0 outer1
// inner1, one vertex per cycle while ready is high. an index at or above the
// segment count is taken and gives no vertex.
// the configuration port writes one register per cycle with cfg_we high.
// an item that is taken passes through the pipeline, whose first stage
// loads at the taking edge, and then the vertex buffer. both segment edges
// run side by side; a new item can enter every cycle until the vertex
// buffer fills; from then on the one vertex per cycle output channel
// sets the pace.
// when the receiver stalls, the buffer holds its vertex and the pipeline
// freezes once its last stage holds an item; nothing is lost or repeated.
// reset empties the pipeline and loads the register defaults.
`default_nettype none

module ring_sector_tessellator_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rst_pkg::CFG_DATA_W-1:0]   cfg_data,
    rst_seg_if.sink                               seg_in,
    rst_vtx_if.source                             vtx_out
);
    import rst_pkg::*;

    logic [SEG_W-1:0] seg_count_reg;
    logic [15:0]      inner_radius_reg;
    logic [15:0]      outer_radius_reg;
    logic [15:0]      first_angle_reg;
    logic [15:0]      last_angle_reg;
    logic [15:0]      first_scale_reg;
    logic [15:0]      last_scale_reg;

    cfg_t                   cfg_w;
    logic signed [15:0]     fa_w;
    logic signed [15:0]     la_w;
    logic                   adv;
    logic                   buf_load;
    logic                   pipe_valid;
    logic [IDX_W-1:0]       pipe_index;
    edge_res_t [LANES-1:0]  pipe_res;

    logic                   buf_valid_reg;
    logic                   buf_valid_next;
    logic [VCNT_W-1:0]      buf_cnt_reg;
    logic [VCNT_W-1:0]      buf_cnt_next;
    logic [IDX_W-1:0]       buf_index_reg;
    edge_res_t [LANES-1:0]  buf_res_reg;
    logic                   edge_sel;
    logic                   outer_sel;
    edge_res_t              sel_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg    <= 9'd3;
            inner_radius_reg <= 16'd0;
            outer_radius_reg <= 16'd256;
            first_angle_reg  <= 16'd0;
            last_angle_reg   <= 16'd25736;
            first_scale_reg  <= 16'd4096;
            last_scale_reg   <= 16'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEGMENT_COUNT: seg_count_reg    <= cfg_data[SEG_W-1:0];
                CFG_INNER_RADIUS:  inner_radius_reg <= cfg_data;
                CFG_OUTER_RADIUS:  outer_radius_reg <= cfg_data;
                CFG_FIRST_ANGLE:   first_angle_reg  <= cfg_data;
                CFG_LAST_ANGLE:    last_angle_reg   <= cfg_data;
                CFG_FIRST_SCALE:   first_scale_reg  <= cfg_data;
                CFG_LAST_SCALE:    last_scale_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the registers into a usable ring
    assign fa_w = $signed(first_angle_reg);
    assign la_w = $signed(last_angle_reg);

    always_comb
    begin
        if (seg_count_reg < SEG_W'(MIN_SEGMENTS))
            cfg_w.n = SEG_W'(MIN_SEGMENTS);
        else if (seg_count_reg > SEG_W'(MAX_SEGMENTS))
            cfg_w.n = SEG_W'(MAX_SEGMENTS);
        else
            cfg_w.n = seg_count_reg;
        cfg_w.ri = {1'b0, inner_radius_reg};
        if (outer_radius_reg <= inner_radius_reg)
            cfg_w.ro = {1'b0, inner_radius_reg} + RAD_W'(HALF_UNIT);
        else
            cfg_w.ro = {1'b0, outer_radius_reg};
        if (la_w < fa_w)
        begin
            cfg_w.a0 = la_w;
            cfg_w.da = 16'(fa_w - la_w);
        end
        else
        begin
            cfg_w.a0 = fa_w;
            cfg_w.da = 16'(la_w - fa_w);
        end
        cfg_w.s0 = first_scale_reg[15] ? '0 : first_scale_reg[SCALE_W-1:0];
        cfg_w.s1 = last_scale_reg[15] ? '0 : last_scale_reg[SCALE_W-1:0];
    end

    assign buf_load     = !buf_valid_reg || (buf_cnt_reg == LAST_VERT && vtx_out.ready);
    assign adv          = !pipe_valid || buf_load;
    assign seg_in.ready = adv;

    rst_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (seg_in.valid && ({1'b0, seg_in.segment_index} < cfg_w.n)),
        .in_index  (seg_in.segment_index),
        .cfg       (cfg_w),
        .out_valid (pipe_valid),
        .out_index (pipe_index),
        .out_res   (pipe_res)
    );

    // vertex buffer: holds both edges of one segment
    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        buf_cnt_next   = buf_cnt_reg;
        if (buf_valid_reg && vtx_out.ready)
        begin
            if (buf_cnt_reg == LAST_VERT)
                buf_valid_next = 1'b0;
            else
                buf_cnt_next = buf_cnt_reg + VCNT_W'(1);
        end
        if (adv && pipe_valid)
        begin
            buf_valid_next = 1'b1;
            buf_cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            buf_cnt_reg   <= '0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            buf_cnt_reg   <= buf_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && pipe_valid)
        begin
            buf_index_reg <= pipe_index;
            buf_res_reg   <= pipe_res;
        end
    end

    assign edge_sel  = PICK_EDGE[buf_cnt_reg];
    assign outer_sel = PICK_OUTER[buf_cnt_reg];
    assign sel_res   = buf_res_reg[edge_sel];

    assign vtx_out.valid         = buf_valid_reg;
    assign vtx_out.vertex_x      = outer_sel ? sel_res.x_out : sel_res.x_in;
    assign vtx_out.vertex_y      = outer_sel ? sel_res.y_out : sel_res.y_in;
    assign vtx_out.tex_u         = sel_res.u;
    assign vtx_out.tex_v         = !outer_sel;
    assign vtx_out.vertex_number = VNUM_W'(buf_index_reg) * VNUM_W'(VERT_PER_SEG)
                                 + VNUM_W'(buf_cnt_reg);
    assign vtx_out.final_vertex  = (buf_cnt_reg == LAST_VERT);

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg && !(buf_cnt_reg == LAST_VERT && vtx_out.ready) |-> !(adv && pipe_valid))
        else $error("vertex buffer overwritten before its segment was sent");

    a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid && !adv |=> pipe_valid && $stable(pipe_index))
        else $error("stalled pipeline lost its item");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= LAST_VERT)
        else $error("vertex counter out of range");

    a_last_then_new: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg && vtx_out.ready && buf_cnt_reg == LAST_VERT |=>
        !buf_valid_reg || buf_cnt_reg == '0)
        else $error("segment did not restart at its first vertex");

endmodule

`default_nettype wire
